// ===== design/swtt_pkg.sv =====
package swtt_pkg;

    // request codes
    localparam logic [1:0] FUNC_TICK     = 2'd0;
    localparam logic [1:0] FUNC_REGISTER = 2'd1;
    localparam logic [1:0] FUNC_REMOVE   = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_FIRED      = 3'd0;
    localparam logic [2:0] KIND_REGISTERED = 3'd1;
    localparam logic [2:0] KIND_FULL       = 3'd2;
    localparam logic [2:0] KIND_REMOVED    = 3'd3;
    localparam logic [2:0] KIND_NOT_FOUND  = 3'd4;

    // slot modes
    localparam logic [1:0] MODE_FREE     = 2'd0;
    localparam logic [1:0] MODE_PERIODIC = 2'd1;
    localparam logic [1:0] MODE_SINGLE   = 2'd2;

    localparam int TICK_W       = 10;
    localparam int PERIOD_W     = 16;
    localparam int PERIOD_RND_W = 17;
    localparam int DIV_CNT_W    = $clog2(PERIOD_W);
    localparam int MAX_RESULTS  = 16;
    localparam int NFIRE_W      = $clog2(MAX_RESULTS + 1);
    localparam int CB_W         = 8;

    typedef struct packed {
        logic [1:0]          func;
        logic [PERIOD_W-1:0] req_period;
        logic                one_shot;
        logic [CB_W-1:0]     callback_id;
    } t_in;

    typedef struct packed {
        logic [2:0]      kind;
        logic [3:0]      slot;
        logic [CB_W-1:0] fired_callback;
        logic            last;
    } t_out;

endpackage

// ===== design/software_timer_table.sv =====
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_stall    | i_in_data  (swtt_pkg::t_in)
// out     | output    | o_out_valid / i_out_stall  | o_out_data (swtt_pkg::t_out)
// cfg     | input     | i_cfg_we (no wait)         | i_cfg_wdata (tick period, ms)
//
// Request handling, output free: a tick reads one slot per cycle, then flushes the
// held result; a remove scans for the callback; a register takes a 16-step period
// remainder, then a free-slot search; func 3 is dropped with no result.
// Reset is synchronous, active low: all slots free, time zero, tick period 10 ms.
// Slot memory is never cleared; a free slot's entry is never used for a result.
// A stalled output holds the scan when a result is to be loaded; a request may be taken while the last result waits.
module software_timer_table #(
    parameter int SLOTS      = 16,
    parameter int TIME_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  swtt_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output swtt_pkg::t_out   o_out_data,
    input  logic             i_cfg_we,
    input  logic [swtt_pkg::TICK_W-1:0] i_cfg_wdata
);
    import swtt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    // compare width for elapsed time against rounded period
    localparam int CW = (TIME_WIDTH > PERIOD_RND_W) ? TIME_WIDTH : PERIOD_RND_W;

    typedef struct packed {
        logic [PERIOD_RND_W-1:0] period;
        logic [TIME_WIDTH-1:0]   stamp;
        logic [CB_W-1:0]         callback;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // slot memory: period, stamp and callback; one write and one read port
    t_entry mem [SLOTS];
    t_entry r_rd_data;

    t_state                  r_state;
    logic [1:0]              r_mode [SLOTS];
    logic [TIME_WIDTH-1:0]   r_now;
    logic [TICK_W-1:0]       r_tick;
    logic [IW-1:0]           r_idx;
    logic [1:0]              r_func;
    logic                    r_one_shot;
    logic [CB_W-1:0]         r_cb;
    logic [PERIOD_W-1:0]     r_period;
    logic [PERIOD_W-1:0]     r_dvd;
    logic [TICK_W-1:0]       r_rem;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic [PERIOD_RND_W-1:0] r_round;
    logic [NFIRE_W-1:0]      r_nfire;
    logic                    r_pend_valid;
    logic [IW-1:0]           r_pend_slot;
    logic [CB_W-1:0]         r_pend_cb;
    logic                    r_out_valid;
    t_out                    r_out;

    logic                    in_xfer;
    logic                    out_xfer;
    logic                    out_free;
    logic                    idx_last;
    logic                    slot_used;
    logic [TICK_W-1:0]       tick_eff;
    logic [TIME_WIDTH-1:0]   elapsed;
    logic                    due;
    logic [TICK_W:0]         div_trial;
    logic                    div_ge;
    logic [TICK_W-1:0]       n_rem;
    logic [PERIOD_RND_W-1:0] n_round;
    logic [IW-1:0]           n_idx;
    logic                    proceed;
    logic                    out_load;
    t_out                    n_out;
    logic                    mem_we;
    t_entry                  mem_wdata;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a zero tick period counts as one
    assign tick_eff  = (r_tick == '0) ? TICK_W'(1) : r_tick;
    assign idx_last  = (r_idx == IW'(SLOTS - 1));
    assign slot_used = (r_mode[r_idx] != MODE_FREE);

    // wrapping elapsed time; the fire count caps results per tick
    assign elapsed = r_now - r_rd_data.stamp;
    assign due     = slot_used && (CW'(elapsed) >= CW'(r_rd_data.period))
                     && (r_nfire < NFIRE_W'(MAX_RESULTS));

    // restoring division step, remainder only
    assign div_trial = {r_rem, r_dvd[PERIOD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, tick_eff});
    assign n_rem     = div_ge ? TICK_W'(div_trial - {1'b0, tick_eff}) : TICK_W'(div_trial);
    assign n_round   = (n_rem != '0)
                     ? PERIOD_RND_W'({1'b0, r_period} - PERIOD_RND_W'(n_rem)
                                     + PERIOD_RND_W'(tick_eff))
                     : PERIOD_RND_W'(r_period);

    // scan decisions for the slot whose data sits in r_rd_data
    always_comb begin
        proceed   = 1'b0;
        out_load  = 1'b0;
        n_out     = '0;
        mem_we    = 1'b0;
        mem_wdata = r_rd_data;
        n_idx     = '0;
        case (r_state)
            ST_SCAN: begin
                case (r_func)
                    FUNC_TICK: begin
                        // a due slot pushes the previous one out, last cleared
                        proceed = !(due && r_pend_valid) || out_free;
                        if (due && r_pend_valid) begin
                            out_load = out_free;
                            n_out    = '{KIND_FIRED, 4'(r_pend_slot), r_pend_cb, 1'b0};
                        end
                        if (proceed && due && (r_mode[r_idx] != MODE_SINGLE)) begin
                            mem_we          = 1'b1;
                            mem_wdata.stamp = r_now;
                        end
                    end
                    FUNC_REGISTER: begin
                        if (!slot_used) begin
                            proceed  = out_free;
                            out_load = out_free;
                            n_out    = '{KIND_REGISTERED, 4'(r_idx), r_cb, 1'b1};
                            mem_we   = out_free;
                            mem_wdata = '{r_round, r_now, r_cb};
                        end else if (idx_last) begin
                            proceed  = out_free;
                            out_load = out_free;
                            n_out    = '{KIND_FULL, 4'd0, r_cb, 1'b1};
                        end else begin
                            proceed = 1'b1;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (slot_used && (r_rd_data.callback == r_cb)) begin
                            proceed  = out_free;
                            out_load = out_free;
                            n_out    = '{KIND_REMOVED, 4'(r_idx), r_cb, 1'b1};
                        end else if (idx_last) begin
                            proceed  = out_free;
                            out_load = out_free;
                            n_out    = '{KIND_NOT_FOUND, 4'd0, r_cb, 1'b1};
                        end else begin
                            proceed = 1'b1;
                        end
                    end
                    default: begin
                        proceed = 1'b1;
                    end
                endcase
                if (!proceed) begin
                    n_idx = r_idx;
                end else if (!idx_last) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_FLUSH: begin
                if (r_pend_valid) begin
                    out_load = out_free;
                    n_out    = '{KIND_FIRED, 4'(r_pend_slot), r_pend_cb, 1'b1};
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // slot memory with registered read; read address follows the next scan index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx] <= mem_wdata;
        end
        r_rd_data <= mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_now        <= '0;
            r_tick       <= TICK_W'(10);
            r_idx        <= '0;
            r_nfire      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_mode[i] <= MODE_FREE;
            end
        end else begin
            if (i_cfg_we) begin
                r_tick <= i_cfg_wdata;
            end
            r_out_valid <= out_load || (r_out_valid && !out_xfer);
            if (out_load) begin
                r_out <= n_out;
            end
            r_idx <= n_idx;

            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_func     <= i_in_data.func;
                        r_one_shot <= i_in_data.one_shot;
                        r_cb       <= i_in_data.callback_id;
                        r_period   <= i_in_data.req_period;
                        r_dvd      <= i_in_data.req_period;
                        r_rem      <= '0;
                        r_cnt      <= '0;
                        r_nfire    <= '0;
                        case (i_in_data.func)
                            FUNC_TICK: begin
                                r_now   <= r_now + TIME_WIDTH'(tick_eff);
                                r_state <= ST_SCAN;
                            end
                            FUNC_REGISTER: r_state <= ST_DIV;
                            FUNC_REMOVE:   r_state <= ST_SCAN;
                            default:       r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[PERIOD_W-2:0], 1'b0};
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(PERIOD_W - 1)) begin
                        r_round <= n_round;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (proceed) begin
                        case (r_func)
                            FUNC_TICK: begin
                                if (due) begin
                                    r_pend_valid <= 1'b1;
                                    r_pend_slot  <= r_idx;
                                    r_pend_cb    <= r_rd_data.callback;
                                    r_nfire      <= r_nfire + NFIRE_W'(1);
                                    if (r_mode[r_idx] == MODE_SINGLE) begin
                                        r_mode[r_idx] <= MODE_FREE;
                                    end
                                end
                                if (idx_last) begin
                                    r_state <= ST_FLUSH;
                                end
                            end
                            FUNC_REGISTER: begin
                                if (!slot_used) begin
                                    r_mode[r_idx] <= r_one_shot ? MODE_SINGLE
                                                                : MODE_PERIODIC;
                                    r_state       <= ST_IDLE;
                                end else if (idx_last) begin
                                    r_state <= ST_IDLE;
                                end
                            end
                            FUNC_REMOVE: begin
                                if (slot_used && (r_rd_data.callback == r_cb)) begin
                                    r_mode[r_idx] <= MODE_FREE;
                                    r_state       <= ST_IDLE;
                                end else if (idx_last) begin
                                    r_state <= ST_IDLE;
                                end
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_valid || out_free) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_pend_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> ((r_state == ST_SCAN && r_func == FUNC_TICK)
                          || r_state == ST_FLUSH))
        else $error("pending fire outside a tick");

    a_fire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfire <= NFIRE_W'(MAX_RESULTS))
        else $error("fire count above limit");

    a_not_last_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_out.kind == KIND_FIRED))
        else $error("non-final result that is not a fire");

    a_time_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_xfer && i_in_data.func == FUNC_TICK) |=> $stable(r_now))
        else $error("time moved without a tick");
`endif

endmodule

// ===== sim/software_timer_table_test.sv =====
`timescale 1ns / 1ps

module software_timer_table_test;
    import swtt_pkg::*;

    localparam int SLOTS       = 16;
    localparam int LIMIT       = 400000;  // cycles before the watchdog gives up
    localparam int SETTLE      = 40;      // covers a register or a silent tick
    localparam int PHASE_ITEMS = 50;      // counted requests per tick-period setting
    localparam int MAX_REPORTS = 10;

    // func 3 has no name in the package; the block drops it without a result
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Shadow copy of the timer table. Every accepted request transfer is
    // replayed here and the results it should cause are queued in order.
    class timer_table_model;
        logic [1:0]              mode   [SLOTS];
        logic [PERIOD_RND_W-1:0] period [SLOTS];
        logic [31:0]             stamp  [SLOTS];
        logic [CB_W-1:0]         owner  [SLOTS];
        logic [31:0]             now_ms;
        logic [TICK_W-1:0]       tick_ms;
        t_out                    due_results[$];
        int                      mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                mode[i]   = MODE_FREE;
                period[i] = '0;
                stamp[i]  = '0;
                owner[i]  = '0;
            end
            now_ms     = '0;
            tick_ms    = TICK_W'(10);
            mismatches = 0;
        endfunction

        // a zero tick period behaves as one millisecond
        function int step_ms();
            return (tick_ms == 0) ? 1 : int'(tick_ms);
        endfunction

        function void set_tick(input logic [TICK_W-1:0] value);
            tick_ms = value;
        endfunction

        function void push_one(input logic [2:0] kind, input int slot_idx,
                               input logic [CB_W-1:0] cb);
            t_out r;
            r.kind           = kind;
            r.slot           = 4'(slot_idx);
            r.fired_callback = cb;
            r.last           = 1'b1;
            due_results.push_back(r);
        endfunction

        function void take_request(input t_in req);
            t_out        held;
            bit          have_held;
            int          fired;
            int          step;
            int          rem;
            int          free_slot;
            logic [31:0] elapsed;

            step      = step_ms();
            have_held = 1'b0;
            fired     = 0;
            free_slot = -1;
            case (req.func)
                FUNC_TICK: begin
                    now_ms = now_ms + 32'(step);
                    for (int i = 0; i < SLOTS; i++) begin
                        if (mode[i] != MODE_FREE && fired < MAX_RESULTS) begin
                            elapsed = now_ms - stamp[i];
                            if (elapsed >= 32'(period[i])) begin
                                // hold back one result so the final one can carry last
                                if (have_held)
                                    due_results.push_back(held);
                                held.kind           = KIND_FIRED;
                                held.slot           = 4'(i);
                                held.fired_callback = owner[i];
                                held.last           = 1'b0;
                                have_held           = 1'b1;
                                fired++;
                                if (mode[i] == MODE_SINGLE)
                                    mode[i] = MODE_FREE;
                                else
                                    stamp[i] = now_ms;
                            end
                        end
                    end
                    if (have_held) begin
                        held.last = 1'b1;
                        due_results.push_back(held);
                    end
                end
                FUNC_REGISTER: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (free_slot < 0 && mode[i] == MODE_FREE)
                            free_slot = i;
                    end
                    if (free_slot < 0) begin
                        push_one(KIND_FULL, 0, req.callback_id);
                    end else begin
                        rem = int'(req.req_period) % step;
                        mode[free_slot]   = req.one_shot ? MODE_SINGLE : MODE_PERIODIC;
                        stamp[free_slot]  = now_ms;
                        period[free_slot] = (rem != 0)
                            ? PERIOD_RND_W'(int'(req.req_period) - rem + step)
                            : PERIOD_RND_W'(req.req_period);
                        owner[free_slot]  = req.callback_id;
                        push_one(KIND_REGISTERED, free_slot, req.callback_id);
                    end
                end
                FUNC_REMOVE: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (free_slot < 0 && mode[i] != MODE_FREE
                                && owner[i] == req.callback_id)
                            free_slot = i;
                    end
                    if (free_slot < 0) begin
                        push_one(KIND_NOT_FOUND, 0, req.callback_id);
                    end else begin
                        mode[free_slot] = MODE_FREE;
                        push_one(KIND_REMOVED, free_slot, req.callback_id);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(input t_out got);
            t_out want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: kind %0d slot %0d cb %02h last %0d",
                             got.kind, got.slot, got.fired_callback, got.last);
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.slot !== want.slot
                    || got.fired_callback !== want.fired_callback
                    || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: expected %0d/%0d/%02h/%0d, got %0d/%0d/%02h/%0d",
                             want.kind, want.slot, want.fired_callback, want.last,
                             got.kind, got.slot, got.fired_callback, got.last);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in               in_data;
    logic              out_valid;
    logic              out_stall;
    t_out              out_data;
    logic              cfg_we;
    logic [TICK_W-1:0] cfg_wdata;
    bit                quiet;     // suppresses idling on both sides

    timer_table_model table_model = new();

    software_timer_table #(
        .SLOTS      (SLOTS),
        .TIME_WIDTH (32)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a run that never drains ends here as a failure.
    initial begin : watchdog
        int n;
        for (n = 0; n < LIMIT; n++)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver back-pressure, changed on the falling edge only.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            out_stall <= !quiet && ($urandom_range(99) < 6);
        end
    end

    // Both channels are watched at the rising edge, where the values seen are
    // those from before the edge. The result is checked ahead of the request
    // noted in the same cycle, since it can only belong to an earlier one.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                table_model.check_result(out_data);
            if (in_valid && !in_stall)
                table_model.take_request(in_data);
        end
    end

    function automatic t_in make_req(input logic [1:0] func, input int period_val,
                                     input bit single, input int cb);
        t_in r;
        r.func        = func;
        r.req_period  = PERIOD_W'(period_val);
        r.one_shot    = single;
        r.callback_id = CB_W'(cb);
        return r;
    endfunction

    // Mostly ticks, registrations and removals over a small callback pool so
    // that removals find their target and the table fills and empties; periods
    // mostly span a handful of ticks so timers actually fire.
    function automatic t_in random_req(input int step);
        t_in r;
        int  pick;
        int  hi;
        pick          = $urandom_range(99);
        hi            = (6 * step > 65535) ? 65535 : 6 * step;
        r.one_shot    = 1'($urandom_range(1));
        r.callback_id = ($urandom_range(9) == 0) ? CB_W'($urandom_range(255))
                                                 : CB_W'($urandom_range(15));
        r.req_period  = ($urandom_range(9) == 0) ? PERIOD_W'($urandom_range(65535))
                                                 : PERIOD_W'($urandom_range(hi));
        if (pick < 4)
            r.func = FUNC_UNUSED;
        else if (pick < 48)
            r.func = FUNC_TICK;
        else if (pick < 78)
            r.func = FUNC_REGISTER;
        else
            r.func = FUNC_REMOVE;
        return r;
    endfunction

    // Called and returns on a falling edge; holds the transfer until accepted.
    task automatic send(input t_in req);
        if (!quiet && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending until every queued result has been seen, then optionally
    // let a silent tick or a late ignored request finish.
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        @(negedge clk);
        while (table_model.due_results.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_tick(input logic [TICK_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        table_model.set_tick(value);
    endtask

    initial begin : stimulus
        logic [TICK_W-1:0] tick_set[5];
        t_in               req;
        int                counted;

        tick_set = '{TICK_W'(1), TICK_W'(1000), TICK_W'(0), TICK_W'(1023), TICK_W'(3)};

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        quiet     = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset tick period of 10 ms: unknown function,
        // an idle tick, a miss on an empty table, zero and largest periods,
        // filling all slots then one more, ticks with many due, remove twice.
        send(make_req(FUNC_UNUSED, 16'hFFFF, 1'b1, 8'hFF));
        send(make_req(FUNC_TICK, 0, 1'b0, 0));
        send(make_req(FUNC_REMOVE, 0, 1'b0, 8'hAA));
        send(make_req(FUNC_REGISTER, 0, 1'b0, 8'h00));
        send(make_req(FUNC_REGISTER, 65535, 1'b1, 8'hFF));
        send(make_req(FUNC_REGISTER, 15, 1'b1, 8'h5A));
        for (int k = 3; k < SLOTS; k++)
            send(make_req(FUNC_REGISTER, 3 * k, k[0], 8'h10 + k));
        send(make_req(FUNC_REGISTER, 100, 1'b0, 8'hC3));
        send(make_req(FUNC_TICK, 0, 1'b0, 0));
        send(make_req(FUNC_TICK, 0, 1'b0, 0));
        send(make_req(FUNC_REMOVE, 0, 1'b0, 8'hFF));
        send(make_req(FUNC_REMOVE, 0, 1'b0, 8'hFF));
        send(make_req(FUNC_TICK, 0, 1'b0, 0));

        // Random part, one phase per tick period; the register only changes
        // once the block has gone quiet.
        for (int p = 0; p < 5; p++) begin
            drain(SETTLE);
            write_tick(tick_set[p]);
            quiet   = (p == 2);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                req = random_req(table_model.step_ms());
                send(req);
                if (req.func != FUNC_UNUSED)
                    counted++;
                if (p == 1 && counted == PHASE_ITEMS / 2)
                    drain(0);
            end
            quiet = 1'b0;
        end

        drain(SETTLE);
        if (table_model.mismatches == 0 && table_model.due_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
